### src/wat_pkg.sv
// Shared types and constants for the weekly alarm table core.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package wat_pkg;

	localparam int MAX_ALARMS  = 16;
	localparam int MAX_REPEATS = 15;
	localparam int IDX_W       = $clog2(MAX_ALARMS);
	localparam int CNT_W       = $clog2(MAX_ALARMS + 1);
	localparam int ID_W        = 5;
	localparam int REP_W       = 4;
	localparam int STAMP_W     = 32;
	localparam int IN_DATA_W   = 88;
	localparam int IN_USER_W   = 2;
	localparam int OUT_DATA_W  = 32;

	localparam logic [7:0] MAX_HOUR   = 8'd23;
	localparam logic [7:0] MAX_MINUTE = 8'd59;

	// item kinds
	localparam logic [1:0] KIND_TICK   = 2'd0;
	localparam logic [1:0] KIND_UPSERT = 2'd1;
	localparam logic [1:0] KIND_REMOVE = 2'd2;

	// result status codes
	localparam logic [2:0] ST_DONE    = 3'd0;
	localparam logic [2:0] ST_FIRED   = 3'd1;
	localparam logic [2:0] ST_NONE    = 3'd2;
	localparam logic [2:0] ST_BADTIME = 3'd3;
	localparam logic [2:0] ST_NODAY   = 3'd4;
	localparam logic [2:0] ST_REPEATS = 3'd5;
	localparam logic [2:0] ST_UNKNOWN = 3'd6;
	localparam logic [2:0] ST_FULL    = 3'd7;

	// per-cell operations
	localparam logic [1:0] CELL_HOLD  = 2'd0;
	localparam logic [1:0] CELL_LOAD  = 2'd1;
	localparam logic [1:0] CELL_SHIFT = 2'd2;
	localparam logic [1:0] CELL_FIRE  = 2'd3;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic               en;
		logic [7:0]         hour;
		logic [7:0]         minute;
		logic [6:0]         days;
		logic [REP_W-1:0]   repeats;
		logic [7:0]         command;
		logic               fired;
		logic [STAMP_W-1:0] last_stamp;
	} entry_t;

	typedef struct packed {
		logic [7:0]         hour;
		logic [7:0]         minute;
		logic [2:0]         weekday;
		logic [STAMP_W-1:0] stamp;
	} now_t;

endpackage
`default_nettype wire

### src/wat_cell.sv
// One alarm slot of the table chain: holds an entry, loads, fires or takes
// its right-hand neighbor's entry. Depends on wat_pkg.
`default_nettype none
module wat_cell (
	input  wire                  clk,
	input  wire [1:0]            op,
	input  wat_pkg::entry_t      load,
	input  wat_pkg::entry_t      next,
	input  wat_pkg::now_t        now,
	output wat_pkg::entry_t      entry,
	output logic                 match
);
	import wat_pkg::*;

	entry_t entry_q;

	assign entry = entry_q;

	// flag a due alarm that has not fired in this minute stamp
	always_comb begin
		match = entry_q.en && entry_q.hour == now.hour && entry_q.minute == now.minute
			&& now.weekday != 3'd7 && entry_q.days[now.weekday]
			&& !(entry_q.fired && entry_q.last_stamp == now.stamp);
	end

	// update the slot
	always_ff @(posedge clk) begin
		unique case (op)
			CELL_LOAD: entry_q <= load;
			CELL_SHIFT: entry_q <= next;
			CELL_FIRE: begin
				entry_q.fired      <= 1'b1;
				entry_q.last_stamp <= now.stamp;
			end
			default: entry_q <= entry_q;
		endcase
	end

endmodule
`default_nettype wire

### src/weekly_alarm_table_core.sv
// Top level of the weekly alarm table: item decode, chain of alarm cells,
// result register. Depends on wat_pkg and wat_cell.
//
//  channel | direction | tdata / tuser                         | transaction
//  s_axis  | in        | item fields / kind                    | one item
//  m_axis  | out       | status,id,command,repeats,count       | one result
//
// An item is captured at one edge and executed at the next, which also loads
// the result register; the result is then offered until it is taken. s_tready
// stays low from capture until the result leaves, so an item passes through
// capture, execute and hand-off before the next is taken. arst_n clears the entry
// count and the handshake state; cell contents are only read below the count.
// A stalled output holds its result and keeps the input closed.
`default_nettype none
module weekly_alarm_table_core (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             s_tvalid,
	output logic                            s_tready,
	// sched_id, enabled, hour, minute, day_mask, repeat_count, command_index,
	// weekday, minute_stamp, time_valid (from bit 0 up)
	input  wire [wat_pkg::IN_DATA_W-1:0]    s_tdata,
	// kind
	input  wire [wat_pkg::IN_USER_W-1:0]    s_tuser,
	output logic                            m_tvalid,
	input  wire                             m_tready,
	// status, result_id, fire_command, fire_repeats, entry_count (from bit 0 up)
	output logic [wat_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import wat_pkg::*;

	logic               busy_q, out_valid_q;
	logic [CNT_W-1:0]   count_q, count_nx;
	logic [1:0]         kind_q;
	logic [ID_W-1:0]    sid_q;
	logic               en_q, tvalid_q;
	logic [7:0]         hour_q, minute_q, days_q, reps_q, cmd_q;
	logic [2:0]         wday_q;
	logic [STAMP_W-1:0] stamp_q;

	logic [2:0]         st_nx, out_st_q;
	logic [ID_W-1:0]    rid_nx, out_rid_q;
	logic [7:0]         rcmd_nx, out_cmd_q;
	logic [REP_W-1:0]   rrep_nx, out_rep_q;
	logic [CNT_W-1:0]   out_cnt_q;

	entry_t             cell_entry [MAX_ALARMS];
	logic [MAX_ALARMS-1:0] cell_match, in_use, hit;
	logic [1:0]         cell_op [MAX_ALARMS];
	entry_t             load_e;
	now_t               now;

	logic               hit_any, match_any, free_any;
	logic [IDX_W-1:0]   hit_idx, match_idx;
	logic [ID_W-1:0]    free_id;
	logic [MAX_ALARMS:1] used;

	assign s_tready = !busy_q && !out_valid_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_cnt_q, out_rep_q, out_cmd_q, out_rid_q, out_st_q};

	assign now = '{hour: hour_q, minute: minute_q, weekday: wday_q, stamp: stamp_q};

	// capture the item
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_q   <= s_tuser;
			sid_q    <= s_tdata[4:0];
			en_q     <= s_tdata[5];
			hour_q   <= s_tdata[13:6];
			minute_q <= s_tdata[21:14];
			days_q   <= s_tdata[29:22];
			reps_q   <= s_tdata[37:30];
			cmd_q    <= s_tdata[45:38];
			wday_q   <= s_tdata[48:46];
			stamp_q  <= s_tdata[80:49];
			tvalid_q <= s_tdata[81];
		end
	end

	// chain of cells, each fed by its right-hand neighbor
	for (genvar g = 0; g < MAX_ALARMS; g++) begin : g_cell
		wat_cell u_cell (
			.clk   (clk),
			.op    (cell_op[g]),
			.load  (load_e),
			.next  (cell_entry[(g + 1 < MAX_ALARMS) ? g + 1 : g]),
			.now   (now),
			.entry (cell_entry[g]),
			.match (cell_match[g])
		);
	end

	// find id hits, first due alarm and lowest free id
	always_comb begin
		hit_any = 1'b0;
		hit_idx = '0;
		match_any = 1'b0;
		match_idx = '0;
		used = '0;
		free_any = 1'b0;
		free_id = '0;
		for (int i = 0; i < MAX_ALARMS; i++) begin
			in_use[i] = CNT_W'(i) < count_q;
			hit[i] = in_use[i] && cell_entry[i].id == sid_q;
			if (hit[i] && !hit_any) begin
				hit_any = 1'b1;
				hit_idx = IDX_W'(i);
			end
			if (in_use[i] && cell_match[i] && !match_any) begin
				match_any = 1'b1;
				match_idx = IDX_W'(i);
			end
		end
		for (int n = 1; n <= MAX_ALARMS; n++) begin
			for (int i = 0; i < MAX_ALARMS; i++) begin
				if (in_use[i] && cell_entry[i].id == ID_W'(n)) used[n] = 1'b1;
			end
		end
		for (int n = 1; n <= MAX_ALARMS; n++) begin
			if (!used[n] && !free_any) begin
				free_any = 1'b1;
				free_id = ID_W'(n);
			end
		end
	end

	// decide the result and the cell operations
	always_comb begin
		st_nx = ST_NONE;
		rid_nx = '0;
		rcmd_nx = '0;
		rrep_nx = '0;
		count_nx = count_q;
		for (int i = 0; i < MAX_ALARMS; i++) cell_op[i] = CELL_HOLD;
		load_e = '{id: (sid_q != '0) ? sid_q : free_id, en: en_q, hour: hour_q,
			minute: minute_q, days: days_q[6:0], repeats: reps_q[REP_W-1:0],
			command: cmd_q, fired: 1'b0, last_stamp: '0};
		if (busy_q) begin
			unique case (kind_q)
				KIND_TICK: begin
					if (tvalid_q && match_any) begin
						cell_op[match_idx] = CELL_FIRE;
						st_nx = ST_FIRED;
						rid_nx = cell_entry[match_idx].id;
						rcmd_nx = cell_entry[match_idx].command;
						rrep_nx = cell_entry[match_idx].repeats;
					end
				end
				KIND_UPSERT: begin
					priority if (hour_q > MAX_HOUR || minute_q > MAX_MINUTE) begin
						st_nx = ST_BADTIME;
					end else if (days_q[6:0] == '0) begin
						st_nx = ST_NODAY;
					end else if (reps_q > 8'(MAX_REPEATS)) begin
						st_nx = ST_REPEATS;
					end else if (sid_q != '0) begin
						if (hit_any) begin
							cell_op[hit_idx] = CELL_LOAD;
							st_nx = ST_DONE;
							rid_nx = sid_q;
						end else begin
							st_nx = ST_UNKNOWN;
						end
					end else if (count_q >= CNT_W'(MAX_ALARMS) || !free_any) begin
						st_nx = ST_FULL;
					end else begin
						cell_op[count_q[IDX_W-1:0]] = CELL_LOAD;
						count_nx = count_q + 1'b1;
						st_nx = ST_DONE;
						rid_nx = free_id;
					end
				end
				KIND_REMOVE: begin
					if (hit_any) begin
						for (int i = 0; i < MAX_ALARMS; i++) begin
							if (IDX_W'(i) >= hit_idx) cell_op[i] = CELL_SHIFT;
						end
						count_nx = count_q - 1'b1;
						st_nx = ST_DONE;
					end else begin
						st_nx = ST_UNKNOWN;
					end
				end
				default: st_nx = ST_NONE;
			endcase
		end
	end

	// control: accept, execute, hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (s_tvalid && s_tready) busy_q <= 1'b1;
			else if (busy_q) busy_q <= 1'b0;
			if (busy_q) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			count_q <= count_nx;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (busy_q) begin
			out_st_q  <= st_nx;
			out_rid_q <= rid_nx;
			out_cmd_q <= rcmd_nx;
			out_rep_q <= rrep_nx;
			out_cnt_q <= count_nx;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ALARMS)) else $error("entry count beyond table size");
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && out_valid_q)) else $error("item executed while result pending");
	a_exec_next: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> busy_q) else $error("accepted item not executed");
	a_result_after: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> out_valid_q && !busy_q) else $error("result not registered");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |=> $stable(count_q)) else $error("count changed while idle");

endmodule
`default_nettype wire

### tb/sv/weekly_alarm_table_core_tb.sv
// Self-checking testbench for weekly_alarm_table_core: drives tick, upsert,
// remove and unused-kind items on the input stream and checks each result
// against a predictor. Depends on wat_pkg and the RTL of the block.
`timescale 1ns / 1ps
module weekly_alarm_table_core_tb;
	import wat_pkg::*;

	localparam int MAX_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  sched_id;
		logic        enabled;
		logic [7:0]  hour;
		logic [7:0]  minute;
		logic [7:0]  day_mask;
		logic [7:0]  repeat_count;
		logic [7:0]  command_index;
		logic [2:0]  weekday;
		logic [31:0] minute_stamp;
		logic        time_valid;
	} alarm_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [4:0] result_id;
		logic [7:0] fire_command;
		logic [3:0] fire_repeats;
		logic [4:0] entry_count;
	} alarm_result_t;

	typedef struct {
		logic [4:0]  id;
		logic        en;
		logic [7:0]  hour;
		logic [7:0]  minute;
		logic [6:0]  days;
		logic [7:0]  repeats;
		logic [7:0]  command;
		logic        fired;
		logic [31:0] stamp;
	} alarm_slot_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata;
	logic [IN_USER_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	weekly_alarm_table_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	alarm_item_t pending_items[$];
	alarm_result_t expected_results[$];
	alarm_slot_t table_model[MAX_ALARMS];
	int table_len;
	int mismatch_count;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_off_left;
	bit hold_off_req;
	bit stimulus_done;
	int cycle_count;
	bit cur_valid;
	int live_ids[$];
	logic [31:0] clock_stamp;

	// clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic int slot_of(input logic [4:0] id);
		for (int i = 0; i < table_len; i++)
			if (table_model[i].id == id)
				return i;
		return -1;
	endfunction

	// predict the result of one item and update the table copy
	function automatic alarm_result_t apply_alarm_item(input alarm_item_t it);
		alarm_result_t r;
		int slot;
		int nid;
		r = '0;
		r.status = ST_NONE;
		case (it.kind)
			KIND_TICK: begin
				if (it.time_valid && it.weekday < 3'd7) begin
					for (int i = 0; i < table_len; i++) begin
						if (!table_model[i].en || table_model[i].hour != it.hour ||
								table_model[i].minute != it.minute ||
								!table_model[i].days[it.weekday] ||
								(table_model[i].fired &&
								table_model[i].stamp == it.minute_stamp))
							continue;
						table_model[i].fired = 1'b1;
						table_model[i].stamp = it.minute_stamp;
						r.status = ST_FIRED;
						r.result_id = table_model[i].id;
						r.fire_command = table_model[i].command;
						r.fire_repeats = table_model[i].repeats[3:0];
						break;
					end
				end
			end
			KIND_UPSERT: begin
				if (it.hour > MAX_HOUR || it.minute > MAX_MINUTE) begin
					r.status = ST_BADTIME;
				end else if (it.day_mask[6:0] == 7'd0) begin
					r.status = ST_NODAY;
				end else if (it.repeat_count > MAX_REPEATS) begin
					r.status = ST_REPEATS;
				end else begin
					slot = -1;
					if (it.sched_id != 5'd0) begin
						slot = slot_of(it.sched_id);
						if (slot < 0)
							r.status = ST_UNKNOWN;
					end else if (table_len >= MAX_ALARMS) begin
						r.status = ST_FULL;
					end else begin
						nid = 1;
						while (nid <= MAX_ALARMS && slot_of(nid[4:0]) >= 0)
							nid++;
						if (nid > MAX_ALARMS) begin
							r.status = ST_FULL;
						end else begin
							slot = table_len;
							table_len++;
							table_model[slot].id = nid[4:0];
						end
					end
					if (slot >= 0) begin
						table_model[slot].en = it.enabled;
						table_model[slot].hour = it.hour;
						table_model[slot].minute = it.minute;
						table_model[slot].days = it.day_mask[6:0];
						table_model[slot].repeats = it.repeat_count;
						table_model[slot].command = it.command_index;
						table_model[slot].fired = 1'b0;
						table_model[slot].stamp = '0;
						r.status = ST_DONE;
						r.result_id = table_model[slot].id;
					end
				end
			end
			KIND_REMOVE: begin
				slot = slot_of(it.sched_id);
				if (slot < 0) begin
					r.status = ST_UNKNOWN;
				end else begin
					for (int i = slot; i + 1 < table_len; i++)
						table_model[i] = table_model[i + 1];
					table_len--;
					r.status = ST_DONE;
				end
			end
			default: ;
		endcase
		r.entry_count = table_len[4:0];
		return r;
	endfunction

	function automatic logic [IN_DATA_W-1:0] pack_fields(input alarm_item_t it);
		return {6'd0, it.time_valid, it.minute_stamp, it.weekday, it.command_index,
			it.repeat_count, it.day_mask, it.minute, it.hour, it.enabled, it.sched_id};
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// driver: offer queued items, predict on acceptance
	always @(posedge clk or negedge arst_n) begin
		alarm_item_t it;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			cur_valid = 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(apply_alarm_item(pending_items.pop_front()));
				cur_valid = 1'b0;
			end
			if (!cur_valid && pending_items.size() > 0 &&
					$urandom_range(99) >= send_idle_pct) begin
				it = pending_items[0];
				s_tdata <= pack_fields(it);
				s_tuser <= it.kind;
				cur_valid = 1'b1;
			end
			s_tvalid <= cur_valid;
		end
	end

	// monitor: random stalls, long hold-off on request, compare results
	always @(posedge clk or negedge arst_n) begin
		alarm_result_t got;
		alarm_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_off_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = '0;
				got.status = m_tdata[2:0];
				got.result_id = m_tdata[7:3];
				got.fire_command = m_tdata[15:8];
				got.fire_repeats = m_tdata[19:16];
				got.entry_count = m_tdata[24:20];
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result, status", got.status, -1);
				end else begin
					want = expected_results.pop_front();
					if (got.status != want.status)
						report_mismatch("status", got.status, want.status);
					if (got.result_id != want.result_id)
						report_mismatch("result_id", got.result_id, want.result_id);
					if (got.fire_command != want.fire_command)
						report_mismatch("fire_command", got.fire_command, want.fire_command);
					if (got.fire_repeats != want.fire_repeats)
						report_mismatch("fire_repeats", got.fire_repeats, want.fire_repeats);
					if (got.entry_count != want.entry_count)
						report_mismatch("entry_count", got.entry_count, want.entry_count);
				end
			end
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_off_left = 300;
			end
			if (hold_off_left > 0) begin
				hold_off_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > MAX_CYCLES) begin
			$display("weekly_alarm_table_core_tb: errors");
			$finish;
		end
	end

	function automatic alarm_item_t blank_item(input logic [1:0] kind);
		alarm_item_t it;
		it = '0;
		it.kind = kind;
		return it;
	endfunction

	function automatic alarm_item_t upsert_item(input logic [4:0] id, input logic [7:0] h,
			input logic [7:0] m, input logic [7:0] days, input logic [7:0] reps);
		alarm_item_t it;
		it = alarm_item_t'($urandom());
		it[$bits(alarm_item_t)-1 -: 32] = $urandom();
		it.kind = KIND_UPSERT;
		it.sched_id = id;
		it.hour = h;
		it.minute = m;
		it.day_mask = days;
		it.repeat_count = reps;
		it.command_index = 8'($urandom_range(255));
		it.enabled = ($urandom_range(9) != 0);
		it.weekday = 3'($urandom_range(7));
		it.minute_stamp = $urandom();
		it.time_valid = 1'($urandom_range(1));
		return it;
	endfunction

	function automatic alarm_item_t tick_item(input logic [7:0] h, input logic [7:0] m,
			input logic [2:0] wd, input logic [31:0] stamp, input logic tv);
		alarm_item_t it;
		it = upsert_item(5'($urandom_range(31)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
		it.kind = KIND_TICK;
		it.hour = h;
		it.minute = m;
		it.weekday = wd;
		it.minute_stamp = stamp;
		it.time_valid = tv;
		return it;
	endfunction

	// one random item, mostly well formed against the live table
	function automatic alarm_item_t random_item();
		alarm_item_t it;
		int pick;
		pick = $urandom_range(99);
		if (pick < 30) begin
			it = upsert_item(($urandom_range(3) == 0) ? 5'($urandom_range(1, 16)) : 5'd0,
				8'($urandom_range(3)), 8'($urandom_range(3)),
				8'($urandom_range(1, 255)) | 8'h01, 8'($urandom_range(15)));
			if ($urandom_range(9) == 0)
				it = upsert_item(5'($urandom_range(31)), 8'($urandom_range(255)),
					8'($urandom_range(255)), 8'($urandom_range(255)),
					8'($urandom_range(255)));
		end else if (pick < 42) begin
			it = blank_item(KIND_REMOVE);
			it.sched_id = ($urandom_range(4) == 0) ? 5'($urandom_range(31)) :
				5'($urandom_range(1, 16));
			it.enabled = 1'($urandom_range(1));
			it.hour = 8'($urandom_range(255));
			it.command_index = 8'($urandom_range(255));
		end else if (pick < 97) begin
			if ($urandom_range(3) == 0)
				clock_stamp = clock_stamp + 32'd1;
			it = tick_item(8'($urandom_range(3)), 8'($urandom_range(3)),
				($urandom_range(19) == 0) ? 3'd7 : 3'($urandom_range(6)),
				($urandom_range(49) == 0) ? $urandom() : clock_stamp,
				($urandom_range(19) != 0));
		end else begin
			it = tick_item(8'($urandom_range(255)), 8'($urandom_range(255)),
				3'($urandom_range(7)), $urandom(), 1'($urandom_range(1)));
			it.kind = 2'd3;
		end
		return it;
	endfunction

	task automatic wait_drained();
		while (pending_items.size() > 0 || cur_valid || expected_results.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		alarm_item_t it;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		table_len = 0;
		mismatch_count = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off_req = 1'b0;
		cycle_count = 0;
		cur_valid = 1'b0;
		clock_stamp = 32'h1000;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, checks in order, full table, removes, ticks
		pending_items.push_back(tick_item(8'd0, 8'd0, 3'd0, 32'd0, 1'b1));
		pending_items.push_back(blank_item(KIND_REMOVE));
		pending_items.push_back(upsert_item(5'd0, 8'd24, 8'd0, 8'h7F, 8'd0));
		pending_items.push_back(upsert_item(5'd0, 8'd0, 8'd60, 8'h7F, 8'd0));
		pending_items.push_back(upsert_item(5'd0, 8'd23, 8'd59, 8'h80, 8'd0));
		pending_items.push_back(upsert_item(5'd0, 8'd23, 8'd59, 8'hFF, 8'd16));
		pending_items.push_back(upsert_item(5'd9, 8'd23, 8'd59, 8'hFF, 8'd15));
		for (int i = 0; i < 17; i++) begin
			it = upsert_item(5'd0, 8'd23, 8'd59, 8'hFF, 8'd15);
			it.enabled = 1'b1;
			pending_items.push_back(it);
		end
		it = blank_item(KIND_REMOVE);
		it.sched_id = 5'd31;
		pending_items.push_back(it);
		it.sched_id = 5'd5;
		pending_items.push_back(it);
		pending_items.push_back(upsert_item(5'd0, 8'd0, 8'd0, 8'h01, 8'd0));
		pending_items.push_back(tick_item(8'd23, 8'd59, 3'd6, 32'hFFFFFFFF, 1'b1));
		pending_items.push_back(tick_item(8'd23, 8'd59, 3'd6, 32'hFFFFFFFF, 1'b1));
		pending_items.push_back(tick_item(8'd23, 8'd59, 3'd7, 32'd7, 1'b1));
		pending_items.push_back(tick_item(8'd23, 8'd59, 3'd2, 32'd7, 1'b0));
		it = tick_item(8'd23, 8'd59, 3'd2, 32'd7, 1'b1);
		it.kind = 2'd3;
		pending_items.push_back(it);
		wait_drained();
		for (int i = 1; i <= 16; i++) begin
			it = blank_item(KIND_REMOVE);
			it.sched_id = 5'(i);
			pending_items.push_back(it);
		end
		wait_drained();

		// random phases with different idle patterns
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 71 : 0;
			recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 19 : 0;
			for (int n = 0; n < 380; n++) begin
				pending_items.push_back(random_item());
				if (n == 100)
					hold_off_req = 1'b1;
				while (pending_items.size() > 4)
					@(posedge clk);
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("weekly_alarm_table_core_tb: clean");
		else
			$display("weekly_alarm_table_core_tb: errors");
		$finish;
	end

endmodule
